// ===== hw/rtl/cas_pkg.sv =====
`default_nettype none

package cas_pkg;

   // Packet geometry
   localparam int SC_KEPT    = 52;
   localparam int FFT_POINTS = 64;
   localparam int SC_EDGE    = 26;   // outermost kept subcarrier on either side
   localparam int SKIP_POS   = 2;    // positions below this drop when flagged

   // Field widths
   localparam int IQ_W    = 8;
   localparam int POS_W   = 7;
   localparam int IDX_W   = 6;
   localparam int KEPT_W  = 7;
   localparam int KEPT_MAX = 127;
   localparam int SEQ_W   = 32;
   localparam int POWER_W = 2 * IQ_W;
   localparam int PSUM_W  = 21;

   // Amplitude format Q8.AMP_FRAC_BITS
   localparam int AMP_FRAC_BITS = 8;
   localparam int AMP_INT_W     = POWER_W / 2;
   localparam int AMP_W         = AMP_INT_W + AMP_FRAC_BITS;
   localparam int RAD_W         = 2 * AMP_W;
   localparam int ROOT_CNT_W    = $clog2(AMP_W);
   localparam int ASUM_W        = AMP_W + $clog2(SC_KEPT);

   // Normalized amplitude Q6.10, mean power Q16.8
   localparam int NORM_W      = 16;
   localparam int NORM_FRAC   = 10;
   localparam int NORM_SCALE  = SC_KEPT << NORM_FRAC;
   localparam int NSCALE_W    = $clog2(NORM_SCALE + 1);
   localparam int MEAN_W      = 24;
   localparam int MEAN_FRAC   = 8;

   // Shared serial divider
   localparam int NORM_NUM_W  = AMP_W + NSCALE_W;
   localparam int MEAN_NUM_W  = PSUM_W + MEAN_FRAC;
   localparam int DIV_NUM_W   = (NORM_NUM_W > MEAN_NUM_W) ? NORM_NUM_W : MEAN_NUM_W;
   localparam int DIV_DEN_W   = ASUM_W;
   localparam int DIV_CNT_W   = $clog2(DIV_NUM_W);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SQRT,
      ST_CLOSE,
      ST_READ,
      ST_NSTART,
      ST_NWAIT,
      ST_NOUT,
      ST_MSTART,
      ST_MWAIT,
      ST_SOUT
   } state_type;

   // Status of a serial arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   typedef struct packed {
      logic                   fill;
      logic [POS_W-1:0]       position;
      logic [IQ_W-1:0]        real_part;
      logic [IQ_W-1:0]        imag_part;
   } req_data_type;

   typedef struct packed {
      logic [1:0]             fill;
      logic [SEQ_W-1:0]       packet_seq;
      logic                   accepted;
      logic [KEPT_W-1:0]      valid_total;
      logic [POWER_W-1:0]     pwr_high;
      logic [POWER_W-1:0]     pwr_low;
      logic [MEAN_W-1:0]      pwr_mean;
      logic [NORM_W-1:0]      norm_amplitude;
      logic [IDX_W-1:0]       amp_index;
   } rsp_data_type;

   localparam int REQ_DATA_W = $bits(req_data_type);
   localparam int RSP_DATA_W = $bits(rsp_data_type);

endpackage

`default_nettype wire

// ===== hw/rtl/cas_isqrt.sv =====
`default_nettype none

// Bit-serial square root of power << (2*AMP_FRAC_BITS), one root bit a cycle.
module cas_isqrt import cas_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [POWER_W-1:0] power,
   output unit_stat_type           stat,
   output logic      [AMP_W-1:0]   root
);

   logic [RAD_W-1:0]      rad_ff, rad_in;
   logic [AMP_W:0]        rem_ff, rem_in;
   logic [AMP_W-1:0]      root_ff, root_in;
   logic [ROOT_CNT_W-1:0] cnt_ff;
   logic                  busy_ff, done_ff;

   logic [AMP_W+2:0]      rem_try;
   logic [AMP_W+2:0]      trial;
   logic [AMP_W+2:0]      diff;
   logic                  fits;

   // Try to subtract 4*root+1 from the remainder with two new radicand bits
   always_comb begin
      rem_try = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      diff    = rem_try - trial;
      fits    = (rem_try >= trial);
      rem_in  = fits ? diff[AMP_W:0] : rem_try[AMP_W:0];
      root_in = {root_ff[AMP_W-2:0], fits};
      rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
   end

   // Track busy and pulse done after the last step
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == ROOT_CNT_W'(AMP_W - 1))) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Load operand, then advance one digit a cycle
   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= {power, {(2 * AMP_FRAC_BITS){1'b0}}};
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         cnt_ff  <= cnt_ff + 1'b1;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign root      = root_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/cas_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit a cycle, shared by normalization and mean.
module cas_div import cas_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DIV_NUM_W-1:0] dividend,
   input  wire logic [DIV_DEN_W-1:0] divisor,
   output unit_stat_type             stat,
   output logic      [DIV_NUM_W-1:0] quotient
);

   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff, done_ff;

   logic [DIV_DEN_W:0]   rem_try;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;

   // Shift in the next dividend bit and subtract when it fits
   always_comb begin
      rem_try = {rem_ff, num_ff[DIV_NUM_W-1]};
      diff    = rem_try - {1'b0, den_ff};
      fits    = (rem_try >= {1'b0, den_ff});
      rem_in  = fits ? diff[DIV_DEN_W-1:0] : rem_try[DIV_DEN_W-1:0];
      num_in  = {num_ff[DIV_NUM_W-2:0], fits};
   end

   // Track busy and pulse done after the last step
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1))) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Load operands, then advance one bit a cycle
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         den_ff <= divisor;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = num_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/csi_subcarrier_amplitude_stats_top.sv =====
// Per-packet amplitude statistics over channel-state pairs.
// Input stream (req_): one word per (imag, real) pair with its FFT position;
// req_tuser flags that positions 0 and 1 are invalid, req_tlast closes the packet.
// Output stream (rsp_): on an accepted packet, 52 normalized amplitude words
// (rsp_tuser = 0) and then one summary word (rsp_tuser = 1, rsp_tlast = 1);
// a rejected packet gives only the summary word.
// A dropped pair, or a kept pair once 52 amplitudes are stored, is captured in
// idle and updated; a kept pair also runs the bit-serial square root (16 steps of
// one root bit). Closing a packet checks it, then each amplitude word and the
// summary is one 32-step pass through the shared serial divider; the summary
// needs no divider pass when no pair was kept.
// Only one pair is in work at a time; req_tready is high while the block waits.
// Results leave through a single output register. A stalled receiver holds the
// current word and pauses emission; once the summary is loaded the next packet's
// pairs are accepted while it waits.
// Reset clears the statistics, the accepted-packet count and both handshakes;
// the amplitude memory is not cleared and needs no clearing pass.
`default_nettype none

module csi_subcarrier_amplitude_stats_top import cas_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [7:0] imag_part, [15:8] real_part, [22:16] position, [23] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [0] skip_first_two
   input  wire logic                  req_tuser,
   input  wire logic                  req_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [5:0] amp_index, [21:6] norm_amplitude, [45:22] pwr_mean,
   // [61:46] pwr_low, [77:62] pwr_high, [84:78] valid_total,
   // [85] accepted, [117:86] packet_seq, [119:118] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // [0] kind
   output logic                       rsp_tuser,
   output logic                       rsp_tlast
);

   state_type state_ff, state_in;

   // Input decode
   req_data_type             req_word;
   logic signed [IQ_W-1:0]   im_s, re_s;
   logic signed [POWER_W-1:0] sq_im, sq_re;
   logic [POWER_W-1:0]       power_in;
   logic [IDX_W-1:0]         pos_low;
   logic                     keep_in;

   // Captured pair
   logic [POWER_W-1:0]       pw_ff;
   logic                     keep_ff;
   logic                     last_ff;

   // Packet statistics
   logic [PSUM_W-1:0]        psum_ff;
   logic [PSUM_W:0]          psum_add;
   logic [PSUM_W-1:0]        psum_in;
   logic [POWER_W-1:0]       pmin_ff, pmax_ff;
   logic [ASUM_W-1:0]        asum_ff;
   logic [KEPT_W-1:0]        kept_ff;
   logic [SEQ_W-1:0]         acc_cnt_ff;
   logic                     ok_ff;
   logic                     pkt_ok;
   logic                     kept_zero;
   logic                     store_room;

   // Amplitude memory
   logic [AMP_W-1:0]         amp_store_ff [SC_KEPT];
   logic [IDX_W-1:0]         wr_idx_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic [AMP_W-1:0]         rd_data_ff;

   // Serial units
   unit_stat_type            sqrt_stat, div_stat;
   logic [AMP_W-1:0]         root;
   logic [DIV_NUM_W-1:0]     div_dividend;
   logic [DIV_DEN_W-1:0]     div_divisor;
   logic [DIV_NUM_W-1:0]     div_quot;

   // FSM outputs
   logic                     sqrt_start;
   logic                     div_start;
   logic                     div_norm;
   logic                     mem_we;
   logic                     out_free;
   logic                     out_load;

   // Output register
   logic                     rsp_valid_ff;
   rsp_data_type             rsp_data_ff, rsp_data_in;
   logic                     rsp_kind_ff;
   logic                     rsp_last_ff;

   // Decode the pair: power and kept-subcarrier test
   always_comb begin
      req_word = req_data_type'(req_tdata);
      im_s     = req_word.imag_part;
      re_s     = req_word.real_part;
      sq_im    = im_s * im_s;
      sq_re    = re_s * re_s;
      power_in = $unsigned(sq_im) + $unsigned(sq_re);
      pos_low  = req_word.position[IDX_W-1:0];
      keep_in  = !req_word.position[POS_W-1]
                 && (((pos_low != '0) && (pos_low <= IDX_W'(SC_EDGE)))
                     || (pos_low >= IDX_W'(FFT_POINTS - SC_EDGE)))
                 && !(req_tuser && (pos_low < IDX_W'(SKIP_POS)));
   end

   assign kept_zero  = (kept_ff == '0);
   assign store_room = (kept_ff < KEPT_W'(SC_KEPT));
   assign pkt_ok     = (kept_ff == KEPT_W'(SC_KEPT)) && (asum_ff != '0);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (keep_ff && store_room) state_in = ST_SQRT;
            else if (last_ff)          state_in = ST_CLOSE;
            else                       state_in = ST_IDLE;
         end
         ST_SQRT:   if (sqrt_stat.done) state_in = last_ff ? ST_CLOSE : ST_IDLE;
         ST_CLOSE:  state_in = pkt_ok ? ST_READ : ST_MSTART;
         ST_READ:   state_in = ST_NSTART;
         ST_NSTART: state_in = ST_NWAIT;
         ST_NWAIT:  if (div_stat.done) state_in = ST_NOUT;
         ST_NOUT: begin
            if (out_free) begin
               state_in = (idx_ff == IDX_W'(SC_KEPT - 1)) ? ST_MSTART : ST_READ;
            end
         end
         ST_MSTART: state_in = kept_zero ? ST_SOUT : ST_MWAIT;
         ST_MWAIT:  if (div_stat.done) state_in = ST_SOUT;
         ST_SOUT:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      req_tready = 1'b0;
      sqrt_start = 1'b0;
      div_start  = 1'b0;
      div_norm   = 1'b0;
      mem_we     = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_tready = !reset;
         ST_UPDATE: sqrt_start = keep_ff && store_room;
         ST_SQRT:   mem_we     = sqrt_stat.done;
         ST_NSTART: begin
            div_start = 1'b1;
            div_norm  = 1'b1;
         end
         ST_NOUT:   out_load   = out_free;
         ST_MSTART: div_start  = !kept_zero;
         ST_SOUT:   out_load   = out_free;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // Capture the accepted pair
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         pw_ff   <= power_in;
         keep_ff <= keep_in;
         last_ff <= req_tlast;
      end
   end

   // Saturating power sum
   always_comb begin
      psum_add = {1'b0, psum_ff} + (PSUM_W + 1)'(pw_ff);
      psum_in  = psum_add[PSUM_W] ? {PSUM_W{1'b1}} : psum_add[PSUM_W-1:0];
   end

   // Update packet statistics, clear them once the summary is loaded
   always_ff @(posedge clock) begin
      if (reset) begin
         psum_ff    <= '0;
         pmin_ff    <= '0;
         pmax_ff    <= '0;
         asum_ff    <= '0;
         kept_ff    <= '0;
         acc_cnt_ff <= '0;
         ok_ff      <= 1'b0;
      end else begin
         if ((state_ff == ST_UPDATE) && keep_ff) begin
            if (kept_zero || (pw_ff < pmin_ff)) pmin_ff <= pw_ff;
            if (kept_zero || (pw_ff > pmax_ff)) pmax_ff <= pw_ff;
            psum_ff <= psum_in;
            if (kept_ff != KEPT_W'(KEPT_MAX)) kept_ff <= kept_ff + 1'b1;
         end
         if (mem_we) asum_ff <= asum_ff + ASUM_W'(root);
         if (state_ff == ST_CLOSE) ok_ff <= pkt_ok;
         if ((state_ff == ST_SOUT) && out_free) begin
            psum_ff <= '0;
            pmin_ff <= '0;
            pmax_ff <= '0;
            asum_ff <= '0;
            kept_ff <= '0;
            if (ok_ff) acc_cnt_ff <= acc_cnt_ff + 1'b1;
         end
      end
   end

   // Memory indexes
   always_ff @(posedge clock) begin
      if (state_ff == ST_UPDATE) wr_idx_ff <= kept_ff[IDX_W-1:0];
      if (state_ff == ST_CLOSE) idx_ff <= '0;
      else if ((state_ff == ST_NOUT) && out_free) idx_ff <= idx_ff + 1'b1;
   end

   // Amplitude memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) amp_store_ff[wr_idx_ff] <= root;
      rd_data_ff <= amp_store_ff[idx_ff];
   end

   cas_isqrt u_isqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (sqrt_start),
      .power  (pw_ff),
      .stat   (sqrt_stat),
      .root   (root)
   );

   // Divider operands: amp*52*1024 / amp_sum, or power_sum*256 / kept_count
   always_comb begin
      if (div_norm) begin
         div_dividend = DIV_NUM_W'(rd_data_ff) * DIV_NUM_W'(NORM_SCALE);
         div_divisor  = asum_ff;
      end else begin
         div_dividend = DIV_NUM_W'({psum_ff, {MEAN_FRAC{1'b0}}});
         div_divisor  = DIV_DEN_W'(kept_ff);
      end
   end

   cas_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   // Assemble the next result word
   always_comb begin
      rsp_data_in = '0;
      if (state_ff == ST_SOUT) begin
         rsp_data_in.pwr_mean    = kept_zero ? '0 : div_quot[MEAN_W-1:0];
         rsp_data_in.pwr_low     = pmin_ff;
         rsp_data_in.pwr_high    = pmax_ff;
         rsp_data_in.valid_total = kept_ff;
         rsp_data_in.accepted    = ok_ff;
         rsp_data_in.packet_seq  = acc_cnt_ff;
      end else begin
         rsp_data_in.amp_index      = idx_ff;
         rsp_data_in.norm_amplitude = div_quot[NORM_W-1:0];
      end
   end

   // Output register: hold until taken
   always_ff @(posedge clock) begin
      if (reset)              rsp_valid_ff <= 1'b0;
      else if (out_load)      rsp_valid_ff <= 1'b1;
      else if (rsp_tready)    rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_kind_ff <= (state_ff == ST_SOUT);
         rsp_last_ff <= (state_ff == ST_SOUT);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Serial units are never restarted mid-operation
   a_sqrt_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      sqrt_start |-> !sqrt_stat.busy)
      else $error("square root restarted while busy");

   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider restarted while busy");

   // Amplitude words only come from a full, accepted packet
   a_amp_only_when_ok: assert property (@(posedge clock) disable iff (reset)
      (out_load && (state_ff == ST_NOUT)) |->
         (ok_ff && (kept_ff == KEPT_W'(SC_KEPT))))
      else $error("amplitude word from a rejected packet");

   // Only the summary word closes the packet
   a_last_is_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == rsp_tlast))
      else $error("packet end not on summary word");

endmodule

`default_nettype wire

// ===== test/csi_subcarrier_amplitude_stats_checker.sv =====
`timescale 1ns / 1ps

module csi_subcarrier_amplitude_stats_checker import cas_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   input  wire logic                  req_tlast,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  rsp_tuser,
   input  wire logic                  rsp_tlast,
   output int                         fail_count,
   output int                         pending,
   output int                         words_checked,
   output int                         packets_accepted
);

   localparam longint unsigned PSUM_MAX = (64'd1 << PSUM_W) - 1;

   // One result word as it leaves the block: kind, last and the data fields
   typedef struct packed {
      logic         kind;
      logic         last;
      rsp_data_type data;
   } rsp_word_type;

   rsp_word_type expected_words[$];

   // Running statistics of the packet in progress
   logic [AMP_W-1:0]   amp_mem [SC_KEPT];
   logic [PSUM_W-1:0]  power_total;
   logic [POWER_W-1:0] power_lo;
   logic [POWER_W-1:0] power_hi;
   logic [ASUM_W-1:0]  amp_total;
   logic [KEPT_W-1:0]  kept_n;
   logic [SEQ_W-1:0]   accepted_seq;

   int           mismatches = 0;
   int           compared = 0;
   int           accepted_packets = 0;
   req_data_type pair_word;
   rsp_data_type got_data;
   rsp_word_type want;

   // Bit-at-a-time square root of power scaled to the amplitude format
   function automatic logic [AMP_W-1:0] amplitude_of(input logic [POWER_W-1:0] pw);
      logic [63:0]      radicand;
      logic [AMP_W-1:0] root;
      logic [AMP_W-1:0] trial;
      radicand = 64'(pw) << (2 * AMP_FRAC_BITS);
      root = '0;
      for (int b = AMP_W - 1; b >= 0; b--) begin
         trial = root | (AMP_W'(1) << b);
         if (64'(trial) * 64'(trial) <= radicand) begin
            root = trial;
         end
      end
      return root;
   endfunction

   // Subcarriers -SC_EDGE..-1 and 1..SC_EDGE pass; flagged positions 0 and 1 drop
   function automatic logic is_kept(input logic [POS_W-1:0] pos, input logic skip);
      int p;
      int sc;
      p = pos;
      sc = (p < FFT_POINTS / 2) ? p : p - FFT_POINTS;
      if (p >= FFT_POINTS || (skip && p < SKIP_POS)) begin
         return 1'b0;
      end
      return (sc >= -SC_EDGE && sc <= -1) || (sc >= 1 && sc <= SC_EDGE);
   endfunction

   task automatic clear_stats();
      power_total = '0;
      power_lo    = '0;
      power_hi    = '0;
      amp_total   = '0;
      kept_n      = '0;
   endtask

   // Fold one kept pair into the packet statistics
   task automatic update_stats(input logic [IQ_W-1:0] im, input logic [IQ_W-1:0] re);
      int                 iv;
      int                 rv;
      logic [POWER_W-1:0] pw;
      longint unsigned    total;
      iv = $signed(im);
      rv = $signed(re);
      pw = POWER_W'(iv * iv + rv * rv);
      if (kept_n == 0 || pw < power_lo) begin
         power_lo = pw;
      end
      if (kept_n == 0 || pw > power_hi) begin
         power_hi = pw;
      end
      total = 64'(power_total) + 64'(pw);
      power_total = (total > PSUM_MAX) ? PSUM_W'(PSUM_MAX) : PSUM_W'(total);
      if (kept_n < SC_KEPT) begin
         amp_mem[kept_n] = amplitude_of(pw);
         amp_total = amp_total + amp_mem[kept_n];
      end
      if (kept_n < KEPT_MAX) begin
         kept_n = kept_n + 1'b1;
      end
   endtask

   // Queue the normalized amplitudes of a good packet, then its summary
   task automatic close_packet();
      logic            ok;
      longint unsigned mean;
      ok = (kept_n == SC_KEPT) && (amp_total != 0);
      if (ok) begin
         for (int k = 0; k < SC_KEPT; k++) begin
            want = '0;
            want.data.amp_index = IDX_W'(k);
            want.data.norm_amplitude =
               NORM_W'((64'(amp_mem[k]) * 64'(NORM_SCALE)) / 64'(amp_total));
            expected_words.push_back(want);
         end
      end
      mean = (kept_n != 0) ? ((64'(power_total) << MEAN_FRAC) / 64'(kept_n)) : 0;
      want = '0;
      want.kind = 1'b1;
      want.last = 1'b1;
      want.data.pwr_mean    = MEAN_W'(mean);
      want.data.pwr_low     = power_lo;
      want.data.pwr_high    = power_hi;
      want.data.valid_total = kept_n;
      want.data.accepted    = ok;
      want.data.packet_seq  = accepted_seq;
      expected_words.push_back(want);
      if (ok) begin
         accepted_seq = accepted_seq + 1'b1;
         accepted_packets++;
      end
      clear_stats();
   endtask

   task automatic compare_field(input string name, input longint unsigned exp_val,
                                input longint unsigned act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_stats();
         accepted_seq = '0;
         expected_words.delete();
      end else begin
         // Check a result word against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            got_data = rsp_tdata;
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected result word, tuser %0d tdata %h",
                        $time, rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want = expected_words.pop_front();
               compare_field("kind", want.kind, rsp_tuser);
               compare_field("last", want.last, rsp_tlast);
               compare_field("amp_index", want.data.amp_index, got_data.amp_index);
               compare_field("norm_amplitude", want.data.norm_amplitude,
                             got_data.norm_amplitude);
               compare_field("pwr_mean", want.data.pwr_mean, got_data.pwr_mean);
               compare_field("pwr_low", want.data.pwr_low, got_data.pwr_low);
               compare_field("pwr_high", want.data.pwr_high, got_data.pwr_high);
               compare_field("valid_total", want.data.valid_total, got_data.valid_total);
               compare_field("accepted", want.data.accepted, got_data.accepted);
               compare_field("packet_seq", want.data.packet_seq, got_data.packet_seq);
               compared++;
            end
         end
         // Predict from an accepted pair word
         if (req_tvalid && req_tready) begin
            pair_word = req_tdata;
            if (is_kept(pair_word.position, req_tuser)) begin
               update_stats(pair_word.imag_part, pair_word.real_part);
            end
            if (req_tlast) begin
               close_packet();
            end
         end
      end
      fail_count       <= mismatches;
      pending          <= expected_words.size();
      words_checked    <= compared;
      packets_accepted <= accepted_packets;
   end

endmodule

// ===== test/csi_subcarrier_amplitude_stats_top_tb.sv =====
`timescale 1ns / 1ps

module csi_subcarrier_amplitude_stats_top_tb import cas_pkg::*; ();

   localparam int HOLD_CYCLES  = 3000;
   localparam int TAIL_CYCLES  = 100;
   localparam int PAIR_TARGET  = 170;
   localparam logic [IQ_W-1:0] IQ_MIN = 8'h80;

   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_PEAK, FILL_SPIKE} fill_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   int fail_count;
   int pending;
   int words_checked;
   int packets_accepted;

   int tx_idle_pct  = 0;
   int rx_stall_pct = 0;
   bit hold_start   = 0;
   int pairs_sent   = 0;
   int packets_sent = 0;
   int kept_list[$];

   initial clock = 1'b0;
   always #2 clock = ~clock;

   csi_subcarrier_amplitude_stats_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   csi_subcarrier_amplitude_stats_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .req_tlast        (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .rsp_tlast        (rsp_tlast),
      .fail_count       (fail_count),
      .pending          (pending),
      .words_checked    (words_checked),
      .packets_accepted (packets_accepted)
   );

   // Receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_start) begin
            hold_start = 0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("Timeout with %0d result words still expected", pending);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [IQ_W-1:0] pick_iq();
      case ($urandom_range(7))
         0:       return IQ_MIN;
         1:       return 8'h7F;
         2:       return 8'h00;
         default: return IQ_W'($urandom_range(255));
      endcase
   endfunction

   // Offer one pair word and hold it until the block takes it
   task automatic send_pair(input logic [IQ_W-1:0] im, input logic [IQ_W-1:0] re,
                            input logic [POS_W-1:0] pos, input logic skip,
                            input logic last);
      req_data_type word;
      word = '0;
      word.imag_part = im;
      word.real_part = re;
      word.position  = pos;
      while ($urandom_range(99) < tx_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= skip;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pairs_sent++;
   endtask

   task automatic send_packet(input int plist[$], input logic skip, input fill_type fill);
      logic [IQ_W-1:0] im;
      logic [IQ_W-1:0] re;
      for (int i = 0; i < plist.size(); i++) begin
         case (fill)
            FILL_ZERO: begin
               im = '0;
               re = '0;
            end
            FILL_PEAK: begin
               im = IQ_MIN;
               re = IQ_MIN;
            end
            FILL_SPIKE: begin
               im = (i == 0) ? IQ_MIN : '0;
               re = (i == 0) ? IQ_MIN : '0;
            end
            default: begin
               im = pick_iq();
               re = pick_iq();
            end
         endcase
         send_pair(im, re, POS_W'(plist[i]), skip, i == plist.size() - 1);
      end
      packets_sent++;
   endtask

   initial begin
      int       plist[$];
      int       pk;
      int       variant;
      int       tmp;
      int       j;
      logic     skip;
      fill_type fill;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      for (int p = 1; p <= SC_EDGE; p++) kept_list.push_back(p);
      for (int p = FFT_POINTS - SC_EDGE; p < FFT_POINTS; p++) kept_list.push_back(p);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Out-of-range position closing an empty packet
      plist = '{127};
      send_packet(plist, 1'b0, FILL_RANDOM);
      // Full sweep of positions, with the receiver held off long enough to back up
      plist = '{};
      for (int p = 0; p < FFT_POINTS; p++) plist.push_back(p);
      hold_start = 1;
      send_packet(plist, 1'b0, FILL_RANDOM);
      plist = '{5, 40, 70};
      send_packet(plist, 1'b1, FILL_PEAK);

      // Random packets, cycling through the idle and stall mixes
      pk = 0;
      while (pairs_sent < PAIR_TARGET || pk < 4) begin
         case (pk % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 77; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 77; end
            default: begin tx_idle_pct = 21; rx_stall_pct = 21; end
         endcase
         skip = 1'($urandom_range(1));
         fill = FILL_RANDOM;
         if ($urandom_range(1) != 0) begin
            // Well-formed: every kept subcarrier once, shuffled
            plist = kept_list;
            for (int i = plist.size() - 1; i > 0; i--) begin
               j = $urandom_range(i);
               tmp = plist[i];
               plist[i] = plist[j];
               plist[j] = tmp;
            end
            if (skip) begin
               foreach (plist[i]) if (plist[i] == 1) plist[i] = 2;
            end
            variant = ($urandom_range(5) == 0) ? $urandom_range(1, 2) : 0;
            if (variant == 1) begin
               plist.delete($urandom_range(plist.size() - 1));
            end else if (variant == 2) begin
               plist.insert($urandom_range(plist.size()), plist[$urandom_range(51)]);
            end
            // Sprinkle in positions that the block drops
            repeat ($urandom_range(4)) begin
               case ($urandom_range(2))
                  0:       tmp = $urandom_range(FFT_POINTS, 127);
                  1:       tmp = $urandom_range(SC_EDGE + 1, FFT_POINTS - SC_EDGE - 1);
                  default: tmp = skip ? $urandom_range(1) : 0;
               endcase
               plist.insert($urandom_range(plist.size()), tmp);
            end
            // Now and then all zero, all at peak or a single nonzero amplitude
            if ($urandom_range(7) == 0) fill = fill_type'($urandom_range(1, 3));
         end else begin
            // Short broken packet of arbitrary positions
            plist = '{};
            repeat ($urandom_range(1, 8)) plist.push_back($urandom_range(127));
         end
         send_packet(plist, skip, fill);
         pk++;
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d pairs in %0d packets: empty, short, skipped, duplicated and full.",
               pairs_sent, packets_sent);
      $display("%0d packets accepted, %0d result words compared across four stall mixes.",
               packets_accepted, words_checked);
      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/cas_pkg.sv
hw/rtl/cas_isqrt.sv
hw/rtl/cas_div.sv
hw/rtl/csi_subcarrier_amplitude_stats_top.sv
test/csi_subcarrier_amplitude_stats_checker.sv
test/csi_subcarrier_amplitude_stats_top_tb.sv
